### rtl/cpr_pkg.sv
package cpr_pkg;

	localparam int FRAME_W = 10;

	localparam logic [1:0] PAGE_BINARY = 2'd0;
	localparam logic [1:0] PAGE_SWAP   = 2'd1;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_FREE   = 3'd1;
	localparam logic [2:0] OP_TOUCH  = 3'd2;
	localparam logic [2:0] OP_PIN    = 3'd3;
	localparam logic [2:0] OP_UNPIN  = 3'd4;
	localparam logic [2:0] OP_EVICT  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_NO_VICTIM = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	localparam logic [4:0] CMD_NOP       = 5'd0;
	localparam logic [4:0] CMD_LATCH     = 5'd1;
	localparam logic [4:0] CMD_INS_WR    = 5'd2;
	localparam logic [4:0] CMD_LOC_INIT  = 5'd3;
	localparam logic [4:0] CMD_RD_CUR    = 5'd4;
	localparam logic [4:0] CMD_LOC_STEP  = 5'd5;
	localparam logic [4:0] CMD_LOC_FOUND = 5'd6;
	localparam logic [4:0] CMD_FLAG      = 5'd7;
	localparam logic [4:0] CMD_EV_INIT   = 5'd8;
	localparam logic [4:0] CMD_EV_STEP   = 5'd9;
	localparam logic [4:0] CMD_EV_NOVIC  = 5'd10;
	localparam logic [4:0] CMD_EV_PICK   = 5'd11;
	localparam logic [4:0] CMD_PR_STEP   = 5'd12;
	localparam logic [4:0] CMD_PR_FOUND  = 5'd13;
	localparam logic [4:0] CMD_RD_SLOT   = 5'd14;
	localparam logic [4:0] CMD_UNLINK    = 5'd15;
	localparam logic [4:0] CMD_RESP      = 5'd16;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [FRAME_W-1:0] frame;
		logic               is_write;
		logic [1:0]         kind;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [FRAME_W-1:0] victim_frame;
		logic               write_to_swap;
	} rsp_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       dirty;
		logic       accessed;
		logic       pinned;
	} flags_t;

	typedef struct packed {
		logic [4:0] op;
		logic       set_status;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       full;
		logic       empty;
		logic       walk_done;
		logic       ev_done;
		logic       match;
		logic       pinned;
		logic       accessed;
		logic       next_is_slot;
		logic       slot_is_head;
		logic       out_free;
	} sts_t;

endpackage

### rtl/clock_page_replacement.sv
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_stall  cpr_pkg::req_t
// rsp       out        rsp_valid / rsp_stall  cpr_pkg::rsp_t
//
// Each request gives exactly one response. Free, touch, pin and unpin walk the
// ring with a read state and a check state per entry, set by the single
// registered read port of the entry memories. Evict reads and checks each entry
// examined (at most twice the entry count), plus the predecessor walk.
// Reset empties the table at once; no clearing pass is needed.
// A request is taken while an earlier response still waits in the output register.
module clock_page_replacement #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cpr_pkg::req_t  req_word,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cpr_pkg::rsp_t  rsp_word
);

	cpr_pkg::cmd_t cmd;
	cpr_pkg::sts_t sts;

	cpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cpr_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in progress");

	a_victim_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_word.status != cpr_pkg::ST_OK)) |->
		((rsp_word.victim_frame == '0) && !rsp_word.write_to_swap))
		else $error("victim reported with a failing status");

	a_resp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a request in progress");
`endif

endmodule

### rtl/cpr_ctrl.sv
module cpr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cpr_pkg::sts_t  sts,
	output cpr_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_LRD  = 4'd2;
	localparam logic [3:0] S_LCHK = 4'd3;
	localparam logic [3:0] S_URD  = 4'd4;
	localparam logic [3:0] S_UL   = 4'd5;
	localparam logic [3:0] S_ERD  = 4'd6;
	localparam logic [3:0] S_ECHK = 4'd7;
	localparam logic [3:0] S_PDEC = 4'd8;
	localparam logic [3:0] S_PRD  = 4'd9;
	localparam logic [3:0] S_PCHK = 4'd10;
	localparam logic [3:0] S_RESP = 4'd11;
	localparam logic [3:0] S_INS  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = cpr_pkg::CMD_NOP;
		cmd.set_status = 1'b0;
		cmd.status = cpr_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = cpr_pkg::CMD_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.opcode)
					cpr_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status = cpr_pkg::ST_FULL;
							state_d = S_RESP;
						end else begin
							state_d = S_INS;
						end
					end
					cpr_pkg::OP_FREE, cpr_pkg::OP_TOUCH, cpr_pkg::OP_PIN,
					cpr_pkg::OP_UNPIN: begin
						cmd.op = cpr_pkg::CMD_LOC_INIT;
						state_d = S_LRD;
					end
					cpr_pkg::OP_EVICT: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = cpr_pkg::ST_EMPTY;
							state_d = S_RESP;
						end else begin
							cmd.op = cpr_pkg::CMD_EV_INIT;
							state_d = S_ERD;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_INS: begin
				cmd.op = cpr_pkg::CMD_INS_WR;
				state_d = S_RESP;
			end
			S_LRD: begin
				if (sts.walk_done) begin
					cmd.set_status = 1'b1;
					cmd.status = cpr_pkg::ST_NOT_FOUND;
					state_d = S_RESP;
				end else begin
					cmd.op = cpr_pkg::CMD_RD_CUR;
					state_d = S_LCHK;
				end
			end
			S_LCHK: begin
				if (sts.match) begin
					if (sts.opcode == cpr_pkg::OP_FREE) begin
						cmd.op = cpr_pkg::CMD_LOC_FOUND;
						state_d = S_URD;
					end else begin
						cmd.op = cpr_pkg::CMD_FLAG;
						state_d = S_RESP;
					end
				end else begin
					cmd.op = cpr_pkg::CMD_LOC_STEP;
					state_d = S_LRD;
				end
			end
			S_URD: begin
				cmd.op = cpr_pkg::CMD_RD_SLOT;
				state_d = S_UL;
			end
			S_UL: begin
				cmd.op = cpr_pkg::CMD_UNLINK;
				state_d = S_RESP;
			end
			S_ERD: begin
				if (sts.ev_done) begin
					cmd.op = cpr_pkg::CMD_EV_NOVIC;
					cmd.set_status = 1'b1;
					cmd.status = cpr_pkg::ST_NO_VICTIM;
					state_d = S_RESP;
				end else begin
					cmd.op = cpr_pkg::CMD_RD_CUR;
					state_d = S_ECHK;
				end
			end
			S_ECHK: begin
				if (!sts.pinned && !sts.accessed) begin
					cmd.op = cpr_pkg::CMD_EV_PICK;
					state_d = S_PDEC;
				end else begin
					cmd.op = cpr_pkg::CMD_EV_STEP;
					state_d = S_ERD;
				end
			end
			S_PDEC: begin
				state_d = sts.slot_is_head ? S_URD : S_PRD;
			end
			S_PRD: begin
				cmd.op = cpr_pkg::CMD_RD_CUR;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (sts.next_is_slot) begin
					cmd.op = cpr_pkg::CMD_PR_FOUND;
					state_d = S_URD;
				end else begin
					cmd.op = cpr_pkg::CMD_PR_STEP;
					state_d = S_PRD;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.op = cpr_pkg::CMD_RESP;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/cpr_dp.sv
module cpr_dp #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cpr_pkg::req_t  req_word,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cpr_pkg::rsp_t  rsp_word,
	input  cpr_pkg::cmd_t  cmd,
	output cpr_pkg::sts_t  sts
);

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [SW:0] CAP_W = (SW+1)'(CAPACITY);

	logic [cpr_pkg::FRAME_W-1:0] frame_mem [CAPACITY];
	cpr_pkg::flags_t             flags_mem [CAPACITY];
	logic [SW-1:0]               next_mem  [CAPACITY];
	logic [SW-1:0]               stack_mem [CAPACITY];

	logic [cpr_pkg::FRAME_W-1:0] frame_rd_q;
	cpr_pkg::flags_t             flags_rd_q;
	logic [SW-1:0]               next_rd_q;
	logic [SW-1:0]               stack_rd_q;

	cpr_pkg::req_t  req_q;
	cpr_pkg::rsp_t  res_q;
	cpr_pkg::rsp_t  out_q;
	logic           out_vld_q;
	logic [SW-1:0]  head_q, tail_q, hand_q, cur_q, slot_q, prev_q;
	logic           hand_vld_q, prev_vld_q;
	logic [SW:0]    count_q, fresh_q, sp_q;
	logic [SW+1:0]  step_q;

	logic [SW-1:0]  raddr, sp_m1, ins_slot, adv;
	logic           fresh_ok;
	logic           frame_we, flags_we, next_we, stack_we;
	logic [SW-1:0]  flags_wa, next_wa, next_wd;
	cpr_pkg::flags_t flags_wd;

	assign raddr    = (cmd.op == cpr_pkg::CMD_RD_SLOT) ? slot_q : cur_q;
	assign sp_m1    = sp_q[SW-1:0] - SW'(1);
	assign fresh_ok = (fresh_q != CAP_W);
	assign ins_slot = fresh_ok ? fresh_q[SW-1:0] : stack_rd_q;
	assign adv      = (cur_q == tail_q) ? head_q : next_rd_q;

	assign sts.opcode       = req_q.opcode;
	assign sts.full         = (count_q == CAP_W);
	assign sts.empty        = (count_q == '0);
	assign sts.walk_done    = (step_q == {1'b0, count_q});
	assign sts.ev_done      = (step_q == {count_q, 1'b0});
	assign sts.match        = (frame_rd_q == req_q.frame);
	assign sts.pinned       = flags_rd_q.pinned;
	assign sts.accessed     = flags_rd_q.accessed;
	assign sts.next_is_slot = (next_rd_q == slot_q);
	assign sts.slot_is_head = (slot_q == head_q);
	assign sts.out_free     = !out_vld_q || !rsp_stall;

	assign rsp_valid = out_vld_q;
	assign rsp_word  = out_q;

	always_comb begin
		frame_we = 1'b0;
		flags_we = 1'b0;
		next_we  = 1'b0;
		stack_we = 1'b0;
		flags_wa = cur_q;
		flags_wd = flags_rd_q;
		next_wa  = tail_q;
		next_wd  = ins_slot;
		case (cmd.op)
			cpr_pkg::CMD_INS_WR: begin
				frame_we = 1'b1;
				flags_we = 1'b1;
				flags_wa = ins_slot;
				flags_wd = '{kind: req_q.kind, dirty: 1'b0, accessed: 1'b0, pinned: 1'b0};
				next_we  = (count_q != '0);
			end
			cpr_pkg::CMD_FLAG: begin
				flags_we = 1'b1;
				case (req_q.opcode)
					cpr_pkg::OP_TOUCH: begin
						flags_wd.accessed = 1'b1;
						flags_wd.dirty = flags_rd_q.dirty | req_q.is_write;
					end
					cpr_pkg::OP_PIN: begin
						flags_wd.pinned = 1'b1;
					end
					default: begin
						flags_wd.pinned = 1'b0;
					end
				endcase
			end
			cpr_pkg::CMD_EV_STEP: begin
				flags_we = !flags_rd_q.pinned;
				flags_wd.accessed = 1'b0;
			end
			cpr_pkg::CMD_UNLINK: begin
				next_we  = prev_vld_q;
				next_wa  = prev_q;
				next_wd  = next_rd_q;
				stack_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[ins_slot] <= req_q.frame;
		end
		if (flags_we) begin
			flags_mem[flags_wa] <= flags_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (stack_we) begin
			stack_mem[sp_q[SW-1:0]] <= slot_q;
		end
		frame_rd_q <= frame_mem[raddr];
		flags_rd_q <= flags_mem[raddr];
		next_rd_q  <= next_mem[raddr];
		stack_rd_q <= stack_mem[sp_m1];
	end

	always_ff @(posedge clk) begin
		if (cmd.set_status) begin
			res_q.status <= cmd.status;
		end
		case (cmd.op)
			cpr_pkg::CMD_LATCH: begin
				req_q <= req_word;
				res_q <= '0;
			end
			cpr_pkg::CMD_LOC_INIT: begin
				cur_q <= head_q;
				step_q <= '0;
				prev_vld_q <= 1'b0;
			end
			cpr_pkg::CMD_LOC_STEP: begin
				prev_q <= cur_q;
				prev_vld_q <= 1'b1;
				cur_q <= next_rd_q;
				step_q <= step_q + 1'b1;
			end
			cpr_pkg::CMD_LOC_FOUND: begin
				slot_q <= cur_q;
			end
			cpr_pkg::CMD_EV_INIT: begin
				cur_q <= hand_vld_q ? hand_q : head_q;
				step_q <= '0;
			end
			cpr_pkg::CMD_EV_STEP: begin
				cur_q <= adv;
				step_q <= step_q + 1'b1;
			end
			cpr_pkg::CMD_EV_NOVIC: begin
				hand_q <= cur_q;
			end
			cpr_pkg::CMD_EV_PICK: begin
				hand_q <= cur_q;
				slot_q <= cur_q;
				prev_vld_q <= 1'b0;
				cur_q <= head_q;
				res_q.victim_frame <= frame_rd_q;
				res_q.write_to_swap <= (flags_rd_q.kind == cpr_pkg::PAGE_SWAP) ||
					((flags_rd_q.kind == cpr_pkg::PAGE_BINARY) && flags_rd_q.dirty);
			end
			cpr_pkg::CMD_PR_STEP: begin
				cur_q <= next_rd_q;
			end
			cpr_pkg::CMD_PR_FOUND: begin
				prev_q <= cur_q;
				prev_vld_q <= 1'b1;
			end
			cpr_pkg::CMD_UNLINK: begin
				if (hand_vld_q && (hand_q == slot_q)) begin
					hand_q <= (slot_q == tail_q) ? head_q : next_rd_q;
				end
			end
			cpr_pkg::CMD_RESP: begin
				out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			hand_vld_q <= 1'b0;
			count_q <= '0;
			fresh_q <= '0;
			sp_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (cmd.op)
				cpr_pkg::CMD_INS_WR: begin
					tail_q <= ins_slot;
					if (count_q == '0) begin
						head_q <= ins_slot;
					end
					count_q <= count_q + 1'b1;
					if (fresh_ok) begin
						fresh_q <= fresh_q + 1'b1;
					end else begin
						sp_q <= sp_q - 1'b1;
					end
				end
				cpr_pkg::CMD_EV_NOVIC, cpr_pkg::CMD_EV_PICK: begin
					hand_vld_q <= 1'b1;
				end
				cpr_pkg::CMD_UNLINK: begin
					if (hand_vld_q && (hand_q == slot_q) && (count_q == (SW+1)'(1))) begin
						hand_vld_q <= 1'b0;
					end
					if (!prev_vld_q) begin
						head_q <= next_rd_q;
					end
					if ((slot_q == tail_q) && prev_vld_q) begin
						tail_q <= prev_q;
					end
					count_q <= count_q - 1'b1;
					sp_q <= sp_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (cmd.op == cpr_pkg::CMD_RESP) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

### verif/tb_clock_page_replacement.sv
`timescale 1ns / 100ps

module tb_clock_page_replacement;

	localparam int SLOTS = 64;
	localparam int NONE = SLOTS;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int FW = cpr_pkg::FRAME_W;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		cpr_pkg::req_t req;
		logic typed;
		cpr_pkg::rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	cpr_pkg::req_t req_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cpr_pkg::rsp_t rsp_word;

	logic [FW-1:0] slot_frame[SLOTS];
	cpr_pkg::flags_t slot_flags[SLOTS];
	int slot_next[SLOTS];
	bit slot_live[SLOTS];
	int head, tail, hand, count;

	cpr_pkg::rsp_t pending_rsp[$];
	int errors = 0;
	int cycles = 0;
	bit hold_long = 1'b0;

	clock_page_replacement #(.CAPACITY(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
	);

	always #6 clk = ~clk;

	function automatic int find_frame(logic [FW-1:0] f, output int prev);
		int cur, p;
		cur = head;
		p = NONE;
		prev = NONE;
		for (int i = 0; i < count; i++) begin
			if (slot_frame[cur] == f) begin
				prev = p;
				return cur;
			end
			p = cur;
			cur = slot_next[cur];
		end
		return NONE;
	endfunction

	function automatic void remove_slot(int s, int prev);
		if (hand == s) begin
			if (count == 1) hand = NONE;
			else if (s == tail) hand = head;
			else hand = slot_next[s];
		end
		if (prev == NONE) head = slot_next[s];
		else slot_next[prev] = slot_next[s];
		if (s == tail && prev != NONE) tail = prev;
		slot_live[s] = 1'b0;
		count--;
	endfunction

	function automatic cpr_pkg::rsp_t table_step(cpr_pkg::req_t r);
		cpr_pkg::rsp_t o;
		int s, prev, steps, lim, cur;
		o = '0;
		case (r.opcode)
			cpr_pkg::OP_INSERT: begin
				if (count >= SLOTS) begin
					o.status = cpr_pkg::ST_FULL;
				end else begin
					s = 0;
					while (slot_live[s]) s++;
					slot_live[s] = 1'b1;
					slot_frame[s] = r.frame;
					slot_flags[s] = '0;
					slot_flags[s].kind = r.kind;
					slot_next[s] = s;
					if (count == 0) head = s;
					else slot_next[tail] = s;
					tail = s;
					count++;
				end
			end
			cpr_pkg::OP_FREE, cpr_pkg::OP_TOUCH, cpr_pkg::OP_PIN, cpr_pkg::OP_UNPIN: begin
				s = find_frame(r.frame, prev);
				if (s == NONE) begin
					o.status = cpr_pkg::ST_NOT_FOUND;
				end else if (r.opcode == cpr_pkg::OP_FREE) begin
					remove_slot(s, prev);
				end else if (r.opcode == cpr_pkg::OP_TOUCH) begin
					slot_flags[s].accessed = 1'b1;
					if (r.is_write) slot_flags[s].dirty = 1'b1;
				end else begin
					slot_flags[s].pinned = (r.opcode == cpr_pkg::OP_PIN);
				end
			end
			cpr_pkg::OP_EVICT: begin
				if (count == 0) begin
					o.status = cpr_pkg::ST_EMPTY;
				end else begin
					if (hand >= NONE || !slot_live[hand]) hand = head;
					lim = 2 * count;
					for (steps = 0; steps < lim; steps++) begin
						if (!slot_flags[hand].pinned) begin
							if (slot_flags[hand].accessed) slot_flags[hand].accessed = 1'b0;
							else break;
						end
						hand = (hand == tail) ? head : slot_next[hand];
					end
					if (steps >= lim) begin
						o.status = cpr_pkg::ST_NO_VICTIM;
					end else begin
						s = hand;
						o.victim_frame = slot_frame[s];
						o.write_to_swap = (slot_flags[s].kind == cpr_pkg::PAGE_SWAP) ||
							(slot_flags[s].kind == cpr_pkg::PAGE_BINARY &&
							slot_flags[s].dirty);
						prev = NONE;
						if (s != head) begin
							cur = head;
							for (int i = 0; i < count; i++) begin
								if (slot_next[cur] == s) begin
									prev = cur;
									break;
								end
								cur = slot_next[cur];
							end
						end
						remove_slot(s, prev);
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic cpr_pkg::req_t make_req(logic [2:0] op, int f, int w, int k);
		cpr_pkg::req_t r;
		r.opcode = op;
		r.frame = FW'(f);
		r.is_write = w[0];
		r.kind = 2'(k);
		return r;
	endfunction

	task automatic send_word(cpr_pkg::req_t r);
		req_valid <= 1'b1;
		req_word <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(table_step(r));
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic cpr_pkg::req_t random_req(int fspan);
		int sel, f, w, k;
		sel = $urandom_range(0, 99);
		f = $urandom_range(0, fspan);
		if ($urandom_range(0, 19) == 0) f = $urandom_range(0, 1023);
		w = $urandom_range(0, 1);
		k = $urandom_range(0, 3);
		if (sel < 30) return make_req(cpr_pkg::OP_INSERT, f, w, k);
		if (sel < 40) return make_req(cpr_pkg::OP_FREE, f, w, k);
		if (sel < 60) return make_req(cpr_pkg::OP_TOUCH, f, w, k);
		if (sel < 67) return make_req(cpr_pkg::OP_PIN, f, w, k);
		if (sel < 74) return make_req(cpr_pkg::OP_UNPIN, f, w, k);
		if (sel < 98) return make_req(cpr_pkg::OP_EVICT, f, w, k);
		return make_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), f, w, k);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_long) rsp_stall <= 1'b1;
			else begin
				n = cycles % 97;
				rsp_stall <= (n < 20) ? 1'b0 : ($urandom_range(0, 2) == 0);
			end
		end
	end

	always @(posedge clk) begin
		cpr_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h", $time, rsp_word);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_word.status !== e.status)
					$display("%0t: status exp %0d got %0d", $time, e.status, rsp_word.status);
				if (rsp_word.victim_frame !== e.victim_frame)
					$display("%0t: victim exp %0d got %0d", $time, e.victim_frame,
						rsp_word.victim_frame);
				if (rsp_word.write_to_swap !== e.write_to_swap)
					$display("%0t: swap exp %0d got %0d", $time, e.write_to_swap,
						rsp_word.write_to_swap);
				if (rsp_word !== e) errors++;
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		cpr_pkg::rsp_t got;
		int fspan;
		for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
		head = 0;
		tail = 0;
		hand = NONE;
		count = 0;
		rows.push_back('{make_req(cpr_pkg::OP_EVICT, 0, 0, 0), 1'b1,
			'{cpr_pkg::ST_EMPTY, 10'd0, 1'b0}});
		rows.push_back('{make_req(cpr_pkg::OP_FREE, 1023, 1, 3), 1'b1,
			'{cpr_pkg::ST_NOT_FOUND, 10'd0, 1'b0}});
		rows.push_back('{make_req(cpr_pkg::OP_INSERT, 1023, 0, cpr_pkg::PAGE_SWAP), 1'b1,
			'{cpr_pkg::ST_OK, 10'd0, 1'b0}});
		rows.push_back('{make_req(cpr_pkg::OP_INSERT, 0, 1, cpr_pkg::PAGE_BINARY), 1'b1,
			'{cpr_pkg::ST_OK, 10'd0, 1'b0}});
		rows.push_back('{make_req(cpr_pkg::OP_INSERT, 0, 0, 2), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_INSERT, 7, 0, 3), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_TOUCH, 0, 1, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_TOUCH, 7, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_PIN, 1023, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(OP_SPARE_LO, 5, 1, 3), 1'b1,
			'{cpr_pkg::ST_OK, 10'd0, 1'b0}});
		rows.push_back('{make_req(OP_SPARE_HI, 0, 0, 0), 1'b1,
			'{cpr_pkg::ST_OK, 10'd0, 1'b0}});
		rows.push_back('{make_req(cpr_pkg::OP_EVICT, 0, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_EVICT, 0, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_PIN, 0, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_EVICT, 0, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_UNPIN, 1023, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_UNPIN, 512, 0, 0), 1'b1,
			'{cpr_pkg::ST_NOT_FOUND, 10'd0, 1'b0}});
		rows.push_back('{make_req(cpr_pkg::OP_EVICT, 0, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_FREE, 0, 0, 0), 1'b0, '0});
		rows.push_back('{make_req(cpr_pkg::OP_EVICT, 0, 0, 0), 1'b1,
			'{cpr_pkg::ST_EMPTY, 10'd0, 1'b0}});
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			rw = rows[i];
			send_word(rw.req);
			got = pending_rsp[$];
			if (rw.typed && got !== rw.rsp) begin
				$display("%0t: table row %0d exp %h got %h", $time, i, rw.rsp, got);
				errors++;
			end
		end
		drain();
		// Fill the table, pin everything, and check the full and no-victim cases.
		for (int i = 0; i < SLOTS + 1; i++) begin
			send_word(make_req(cpr_pkg::OP_INSERT, i, 0, i % 3));
			send_word(make_req(cpr_pkg::OP_PIN, i, 0, 0));
		end
		send_word(make_req(cpr_pkg::OP_EVICT, 0, 0, 0));
		for (int i = 0; i < SLOTS; i++) send_word(make_req(cpr_pkg::OP_UNPIN, i, 0, 0));
		for (int i = 0; i < SLOTS; i++) send_word(make_req(cpr_pkg::OP_EVICT, 0, 0, 0));
		drain();
		hold_long = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
			end
			for (int i = 0; i < 40; i++) send_word(random_req(15));
		join
		drain();
		for (int i = 0; i < 1600; i++) begin
			fspan = (i % 400 < 200) ? 15 : 127;
			if ($urandom_range(0, 9) == 0) idle_gap();
			send_word(random_req(fspan));
		end
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
